// ----- sv/imulp_pkg.sv -----
// ============================================================================
// imulp_pkg
// Shared types, constants and rounding helpers for the six-axis IMU lowpass.
// ============================================================================
package imulp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_FRAC  = 20;
    localparam int STATE_FRAC = 8;
    localparam int STATE_W    = SAMPLE_W + STATE_FRAC;
    localparam int ALPHA_W    = 21;
    localparam int COEF_W     = 24;
    localparam int KSEL_W     = 25;                 // holds alpha and alpha - one
    localparam int PROD_W     = KSEL_W + STATE_W;
    localparam int ACC_W      = PROD_W + 3;         // five products, exact
    localparam int NUM_CH     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [STATE_W-1:0]  state_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [KSEL_W-1:0]   ksel_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [ALPHA_W-1:0]         alpha_t;

    typedef enum logic [1:0] {
        MODE_LPF    = 2'd0,
        MODE_BIQUAD = 2'd1,
        MODE_PASS   = 2'd2
    } filter_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIQUAD_B0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIQUAD_B1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIQUAD_B2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIQUAD_FB1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIQUAD_FB2  = 3'd6;

    localparam alpha_t ALPHA_RST = 21'd142392;
    localparam coef_t  B0_RST    = 24'sd5812;
    localparam coef_t  B1_RST    = 24'sd11624;
    localparam coef_t  B2_RST    = 24'sd5812;
    localparam coef_t  FB1_RST   = -24'sd1864950;
    localparam coef_t  FB2_RST   = 24'sd839700;

    localparam ksel_t COEF_ONE = ksel_t'(1) <<< COEF_FRAC;

    // Coefficients as seen by the datapath; the y terms are subtracted.
    typedef struct packed {
        filter_mode_t mode;
        ksel_t        kx0;
        ksel_t        kx1;
        ksel_t        kx2;
        ksel_t        ky1;
        ksel_t        ky2;
    } coef_set_t;

    // Round half up at the coefficient point, then clamp to the state width.
    function automatic state_t round_sat_state(input acc_t acc);
        logic signed [ACC_W:0] rnd;
        logic signed [ACC_W:0] shf;
        logic signed [ACC_W:0] half;
        state_t                res;
        half = (ACC_W+1)'(1) <<< (COEF_FRAC - 1);
        rnd  = $signed({acc[ACC_W-1], acc}) + half;
        shf  = rnd >>> COEF_FRAC;
        if ((shf[ACC_W:STATE_W-1] == '0) || (shf[ACC_W:STATE_W-1] == '1)) begin
            res = shf[STATE_W-1:0];
        end else begin
            res = {shf[ACC_W], {(STATE_W-1){~shf[ACC_W]}}};
        end
        return res;
    endfunction

    // Round half up to an integer sample, then clamp to the sample width.
    function automatic sample_t round_sat_sample(input state_t y);
        logic signed [STATE_W:0] rnd;
        logic signed [STATE_W:0] shf;
        logic signed [STATE_W:0] half;
        sample_t                 res;
        half = (STATE_W+1)'(1) <<< (STATE_FRAC - 1);
        rnd  = $signed({y[STATE_W-1], y}) + half;
        shf  = rnd >>> STATE_FRAC;
        if ((shf[STATE_W:SAMPLE_W-1] == '0) || (shf[STATE_W:SAMPLE_W-1] == '1)) begin
            res = shf[SAMPLE_W-1:0];
        end else begin
            res = {shf[STATE_W], {(SAMPLE_W-1){~shf[STATE_W]}}};
        end
        return res;
    endfunction

endpackage

// ----- sv/imulp_chan.sv -----
// ============================================================================
// imulp_chan
// One filter channel: histories, five-tap multiply-accumulate, rounding.
// ============================================================================
module imulp_chan (
    input  logic                 aclk,
    input  logic                 fire,
    input  logic                 prime,
    input  imulp_pkg::sample_t   sample,
    input  imulp_pkg::coef_set_t coef,
    output imulp_pkg::sample_t   result
);
    import imulp_pkg::*;

    sample_t in_h1_reg;
    sample_t in_h2_reg;
    state_t  out_h1_reg;
    state_t  out_h2_reg;

    state_t  xq;
    state_t  x1q;
    state_t  x2q;
    ksel_t   kx0, kx1, kx2, ky1, ky2;
    logic signed [PROD_W-1:0] p_x0, p_x1, p_x2, p_y1, p_y2;
    acc_t    acc;
    state_t  filt;
    state_t  y_next;

    assign xq  = {sample,    {STATE_FRAC{1'b0}}};
    assign x1q = {in_h1_reg, {STATE_FRAC{1'b0}}};
    assign x2q = {in_h2_reg, {STATE_FRAC{1'b0}}};

    assign kx0 = coef.kx0;
    assign kx1 = coef.kx1;
    assign kx2 = coef.kx2;
    assign ky1 = coef.ky1;
    assign ky2 = coef.ky2;

    assign p_x0 = kx0 * xq;
    assign p_x1 = kx1 * x1q;
    assign p_x2 = kx2 * x2q;
    assign p_y1 = ky1 * out_h1_reg;
    assign p_y2 = ky2 * out_h2_reg;

    assign acc = ACC_W'(p_x0) + ACC_W'(p_x1) + ACC_W'(p_x2)
               - ACC_W'(p_y1) - ACC_W'(p_y2);

    assign filt = round_sat_state(acc);

    // Unused mode code falls through to passthrough.
    always_comb begin
        unique case (coef.mode)
            MODE_LPF,
            MODE_BIQUAD: y_next = filt;
            default:     y_next = xq;
        endcase
    end

    assign result = round_sat_sample(y_next);

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (prime) begin
                in_h1_reg  <= sample;
                in_h2_reg  <= sample;
                out_h1_reg <= xq;
                out_h2_reg <= xq;
            end else begin
                in_h1_reg  <= sample;
                in_h2_reg  <= in_h1_reg;
                out_h1_reg <= y_next;
                out_h2_reg <= out_h1_reg;
            end
        end
    end

endmodule

// ----- sv/imu_six_axis_lowpass.sv -----
// ============================================================================
// imu_six_axis_lowpass
// Six-channel IMU filter: first-order lowpass, DF-I biquad or passthrough.
// ============================================================================
//
//  channel  | ports                      | role
//  ---------+----------------------------+-------------------------------------
//  input    | s_valid/s_ready, s_*       | one item = six raw 16-bit samples
//  result   | m_valid/m_ready, m_*       | one item = six filtered samples
//  config   | cfg_wr_en/cfg_index/cfg_data | register writes, no handshake
//
//  Throughput: one item per cycle while m_ready does not stall the result.
//  An accepted item passes the input register, then the result register;
//  the MAC, rounding and the history update of all six channels sit
//  between those two registers.
//  The first item after reset only primes the histories and gives no result.
//  Reset (aresetn low, synchronous) empties both registers and restores the
//  register defaults; histories are loaded by the priming item.
//  With m_ready low the result holds; one more item parks in the input
//  register, after which s_ready drops.
//
module imu_six_axis_lowpass (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [imulp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [imulp_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  imulp_pkg::sample_t                    s_accel_x,
    input  imulp_pkg::sample_t                    s_accel_y,
    input  imulp_pkg::sample_t                    s_accel_z,
    input  imulp_pkg::sample_t                    s_gyro_x,
    input  imulp_pkg::sample_t                    s_gyro_y,
    input  imulp_pkg::sample_t                    s_gyro_z,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output imulp_pkg::sample_t                    m_accel_x_filtered,
    output imulp_pkg::sample_t                    m_accel_y_filtered,
    output imulp_pkg::sample_t                    m_accel_z_filtered,
    output imulp_pkg::sample_t                    m_gyro_x_filtered,
    output imulp_pkg::sample_t                    m_gyro_y_filtered,
    output imulp_pkg::sample_t                    m_gyro_z_filtered
);
    import imulp_pkg::*;

    // ---------------- configuration registers ----------------
    filter_mode_t mode_reg;
    alpha_t       alpha_reg;
    coef_t        b0_reg, b1_reg, b2_reg, fb1_reg, fb2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_LPF;
            alpha_reg <= ALPHA_RST;
            b0_reg    <= B0_RST;
            b1_reg    <= B1_RST;
            b2_reg    <= B2_RST;
            fb1_reg   <= FB1_RST;
            fb2_reg   <= FB2_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FILTER_MODE: mode_reg  <= filter_mode_t'(cfg_data[1:0]);
                REG_ALPHA:       alpha_reg <= cfg_data[ALPHA_W-1:0];
                REG_BIQUAD_B0:   b0_reg    <= cfg_data[COEF_W-1:0];
                REG_BIQUAD_B1:   b1_reg    <= cfg_data[COEF_W-1:0];
                REG_BIQUAD_B2:   b2_reg    <= cfg_data[COEF_W-1:0];
                REG_BIQUAD_FB1:  fb1_reg   <= cfg_data[COEF_W-1:0];
                REG_BIQUAD_FB2:  fb2_reg   <= cfg_data[COEF_W-1:0];
                default: ;       // unmapped index, write dropped
            endcase
        end
    end

    // Map both filters onto the same five-tap MAC. The lowpass uses
    // alpha on x and (alpha - one) on y1, which the MAC subtracts.
    coef_set_t coef_sel;
    ksel_t     alpha_s;

    assign alpha_s = $signed({{(KSEL_W-ALPHA_W){1'b0}}, alpha_reg});

    always_comb begin
        coef_sel      = '0;
        coef_sel.mode = mode_reg;
        unique case (mode_reg)
            MODE_LPF: begin
                coef_sel.kx0 = alpha_s;
                coef_sel.ky1 = alpha_s - COEF_ONE;
            end
            MODE_BIQUAD: begin
                coef_sel.kx0 = KSEL_W'(b0_reg);
                coef_sel.kx1 = KSEL_W'(b1_reg);
                coef_sel.kx2 = KSEL_W'(b2_reg);
                coef_sel.ky1 = KSEL_W'(fb1_reg);
                coef_sel.ky2 = KSEL_W'(fb2_reg);
            end
            default: ;   // passthrough ignores the MAC
        endcase
    end

    // ---------------- input register ----------------
    logic    in_valid_reg;
    sample_t in_sample_reg [NUM_CH];
    sample_t s_sample      [NUM_CH];

    // ---------------- result register ----------------
    logic    m_valid_reg;
    sample_t m_sample_reg  [NUM_CH];
    sample_t chan_result   [NUM_CH];

    logic    primed_reg;
    logic    fire;       // input register item is processed this cycle
    logic    out_load;   // and it produces a result

    assign s_sample[0] = s_accel_x;
    assign s_sample[1] = s_accel_y;
    assign s_sample[2] = s_accel_z;
    assign s_sample[3] = s_gyro_x;
    assign s_sample[4] = s_gyro_y;
    assign s_sample[5] = s_gyro_z;

    // A priming item never needs the result register.
    assign fire     = in_valid_reg && (!primed_reg || !m_valid_reg || m_ready);
    assign out_load = fire && primed_reg;
    assign s_ready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            primed_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire) begin
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
        if (out_load) begin
            m_sample_reg <= chan_result;
        end
    end

    // ---------------- per-channel datapath ----------------
    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        imulp_chan u_chan (
            .aclk   (aclk),
            .fire   (fire),
            .prime  (!primed_reg),
            .sample (in_sample_reg[c]),
            .coef   (coef_sel),
            .result (chan_result[c])
        );
    end

    assign m_valid            = m_valid_reg;
    assign m_accel_x_filtered = m_sample_reg[0];
    assign m_accel_y_filtered = m_sample_reg[1];
    assign m_accel_z_filtered = m_sample_reg[2];
    assign m_gyro_x_filtered  = m_sample_reg[3];
    assign m_gyro_y_filtered  = m_sample_reg[4];
    assign m_gyro_z_filtered  = m_sample_reg[5];

    // ---------------- assertions ----------------
    // No result may exist before the priming item went through.
    a_no_result_unprimed: assert property (@(posedge aclk) disable iff (!aresetn)
        !primed_reg |-> !m_valid_reg)
        else $error("result present before priming");

    // Backpressure only when the input register is occupied.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("s_ready low with empty input register");

    // A parked item keeps its samples until it is processed.
    a_parked_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_sample_reg[0])))
        else $error("parked item lost or changed");

endmodule

// ----- tb/sv/imu_six_axis_lowpass_tb.sv -----
// ============================================================================
// imu_six_axis_lowpass_tb
// Self-checking bench for the six-axis IMU filter. A shadow predictor runs
// the lowpass, biquad and passthrough math in 64-bit integers. It keeps its
// own register copy and channel histories. Each result item is checked,
// channel by channel, against the oldest predicted item. Directed tests
// cover priming, the alpha and coefficient extremes, the odd mode value and
// the unmapped index. Random phases then reprogram the block between bursts,
// with random bursts of idle cycles on both channels, save in the last phase.
// ============================================================================
module imu_six_axis_lowpass_tb;

    import imulp_pkg::*;

    // One item: index 0..5 = accel x/y/z, gyro x/y/z.
    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] imu_vec_t;

    localparam int  SETTLE_CYCLES = 4;      // two-stage pipe plus margin
    localparam int  IDLE_LIMIT    = 2000;   // cycles without any handshake
    localparam int  PHASES        = 10;
    localparam int  PHASE_ITEMS   = 100;
    localparam int  MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [1:0]           MODE_SPARE   = 2'd3;

    localparam string CH_NAME [NUM_CH] = '{"accel_x", "accel_y", "accel_z",
                                           "gyro_x", "gyro_y", "gyro_z"};

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    sample_t               s_accel_x, s_accel_y, s_accel_z;
    sample_t               s_gyro_x, s_gyro_y, s_gyro_z;
    logic                  m_valid;
    logic                  m_ready;
    sample_t               m_accel_x_filtered, m_accel_y_filtered, m_accel_z_filtered;
    sample_t               m_gyro_x_filtered, m_gyro_y_filtered, m_gyro_z_filtered;

    imu_six_axis_lowpass dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_accel_x          (s_accel_x),
        .s_accel_y          (s_accel_y),
        .s_accel_z          (s_accel_z),
        .s_gyro_x           (s_gyro_x),
        .s_gyro_y           (s_gyro_y),
        .s_gyro_z           (s_gyro_z),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accel_x_filtered (m_accel_x_filtered),
        .m_accel_y_filtered (m_accel_y_filtered),
        .m_accel_z_filtered (m_accel_z_filtered),
        .m_gyro_x_filtered  (m_gyro_x_filtered),
        .m_gyro_y_filtered  (m_gyro_y_filtered),
        .m_gyro_z_filtered  (m_gyro_z_filtered)
    );

    // 4-unit period
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Shadow registers and channel histories
    // ------------------------------------------------------------------------
    logic [1:0] cfg_mode;
    longint     cfg_alpha;
    longint     cfg_b0, cfg_b1, cfg_b2, cfg_fb1, cfg_fb2;

    bit         hist_primed;
    longint     x_hist1 [NUM_CH];   // raw samples
    longint     x_hist2 [NUM_CH];
    longint     y_hist1 [NUM_CH];   // Q16.8 state
    longint     y_hist2 [NUM_CH];

    imu_vec_t   expected_filtered [$];
    int         fail_count;

    // Bench knobs: percent chance to start an idle burst (source: per offered item, sink: per cycle).
    int         src_gap_pct;
    int         sink_stall_pct;
    int         sink_stall_left;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // add half, then floor (arithmetic shift on a signed 64-bit value)
    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Filters one item; the first item after reset only loads the histories.
    function automatic void filter_item(input imu_vec_t din, output bit produced,
                                        output imu_vec_t dout);
        longint xs;
        longint xq;
        longint acc;
        longint y;
        longint r;
        dout = '0;
        if (!hist_primed) begin
            for (int c = 0; c < NUM_CH; c++) begin
                xs = longint'($signed(din[c]));
                x_hist1[c] = xs;
                x_hist2[c] = xs;
                y_hist1[c] = xs <<< STATE_FRAC;
                y_hist2[c] = xs <<< STATE_FRAC;
            end
            hist_primed = 1'b1;
            produced = 1'b0;
            return;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            xs = longint'($signed(din[c]));
            xq = xs <<< STATE_FRAC;
            if (cfg_mode == MODE_LPF) begin
                acc = cfg_alpha * xq
                    + ((longint'(1) <<< COEF_FRAC) - cfg_alpha) * y_hist1[c];
                y = clamp_signed(round_half_up(acc, COEF_FRAC), STATE_W);
            end else if (cfg_mode == MODE_BIQUAD) begin
                acc = cfg_b0 * xq
                    + cfg_b1 * (x_hist1[c] <<< STATE_FRAC)
                    + cfg_b2 * (x_hist2[c] <<< STATE_FRAC)
                    - cfg_fb1 * y_hist1[c]
                    - cfg_fb2 * y_hist2[c];
                y = clamp_signed(round_half_up(acc, COEF_FRAC), STATE_W);
            end else begin
                y = xq;     // passthrough, and the spare mode code
            end
            x_hist2[c] = x_hist1[c];
            x_hist1[c] = xs;
            y_hist2[c] = y_hist1[c];
            y_hist1[c] = y;
            r = clamp_signed(round_half_up(y, STATE_FRAC), SAMPLE_W);
            dout[c] = r[SAMPLE_W-1:0];
        end
        produced = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Register write; the shadow copy follows the block's masking rules.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_FILTER_MODE: cfg_mode  = data[1:0];
            REG_ALPHA:       cfg_alpha = longint'(data[ALPHA_W-1:0]);
            REG_BIQUAD_B0:   cfg_b0    = longint'($signed(data[COEF_W-1:0]));
            REG_BIQUAD_B1:   cfg_b1    = longint'($signed(data[COEF_W-1:0]));
            REG_BIQUAD_B2:   cfg_b2    = longint'($signed(data[COEF_W-1:0]));
            REG_BIQUAD_FB1:  cfg_fb1   = longint'($signed(data[COEF_W-1:0]));
            REG_BIQUAD_FB2:  cfg_fb2   = longint'($signed(data[COEF_W-1:0]));
            default: ;      // unmapped index, no effect
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one item, maybe after an idle burst; predicts it on acceptance.
    task automatic send_item(input imu_vec_t v);
        int       gap;
        bit       produced;
        imu_vec_t res;
        @(negedge aclk);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_accel_x <= v[0];
        s_accel_y <= v[1];
        s_accel_z <= v[2];
        s_gyro_x  <= v[3];
        s_gyro_y  <= v[4];
        s_gyro_z  <= v[5];
        do @(posedge aclk); while (!s_ready);
        filter_item(v, produced, res);
        if (produced)
            expected_filtered.push_back(res);
    endtask

    // Stops offering, waits for every predicted item, then lets the pipe
    // settle so a priming item still in flight cannot see a register write.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic imu_vec_t vec6(input int a, input int b, input int c,
                                      input int d, input int e, input int f);
        imu_vec_t v;
        v[0] = a[SAMPLE_W-1:0];
        v[1] = b[SAMPLE_W-1:0];
        v[2] = c[SAMPLE_W-1:0];
        v[3] = d[SAMPLE_W-1:0];
        v[4] = e[SAMPLE_W-1:0];
        v[5] = f[SAMPLE_W-1:0];
        return v;
    endfunction

    // Mix of full-range noise, small signals, rail values and held samples.
    function automatic imu_vec_t random_sample(input imu_vec_t last);
        imu_vec_t v;
        int       pick;
        for (int c = 0; c < NUM_CH; c++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                v[c] = SAMPLE_W'($urandom);
            else if (pick < 7)
                v[c] = SAMPLE_W'($urandom_range(0, 4000) - 2000);
            else if (pick < 9)
                case ($urandom_range(0, 3))
                    0: v[c] = 16'h7fff;
                    1: v[c] = 16'h8000;
                    2: v[c] = 16'h0000;
                    default: v[c] = 16'hffff;
                endcase
            else
                v[c] = last[c];
        end
        return v;
    endfunction

    // Nudges a default coefficient, or throws a wild one now and then.
    function automatic logic [CFG_DATA_W-1:0] random_coef(input coef_t nominal);
        case ($urandom_range(0, 9))
            0, 1:    return CFG_DATA_W'($urandom);
            2:       return CFG_DATA_W'($urandom_range(0, 2097152) - 1048576);
            3:       return ($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h800000;
            default: return CFG_DATA_W'(int'(nominal) + $urandom_range(0, 64) - 32);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts on m_ready
    // ------------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        sink_stall_left = 0;
        forever begin
            @(negedge aclk);
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_ready <= 1'b0;
            end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                sink_stall_left = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        imu_vec_t got;
        imu_vec_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_gyro_z_filtered, m_gyro_y_filtered, m_gyro_x_filtered,
                   m_accel_z_filtered, m_accel_y_filtered, m_accel_x_filtered};
            if (expected_filtered.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] result item with nothing pending", $realtime);
            end else begin
                want = expected_filtered.pop_front();
                for (int c = 0; c < NUM_CH; c++) begin
                    if (got[c] !== want[c]) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] %s: expected %0d, got %0d", $realtime,
                                     CH_NAME[c], $signed(want[c]), $signed(got[c]));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------------
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults: first item only primes, the rest run the default lowpass.
    task automatic test_priming_defaults();
        send_item(vec6(32767, -32768, 0, -1, 1, 12345));
        send_item(vec6(-32768, 32767, 32767, 0, -32768, 100));
        send_item(vec6(0, 0, -32768, 32767, 32767, -100));
        send_item(vec6(1, -1, 255, -256, 128, -129));
        wait_drained();
    endtask

    // alpha zero holds the state, one follows the input, above one overshoots.
    task automatic test_lowpass_alpha_extremes();
        write_reg(REG_ALPHA, 24'd0);
        send_item(vec6(32767, -32768, 1000, -1000, 0, 7));
        send_item(vec6(-32768, 32767, -1, 1, 5, -5));
        wait_drained();
        write_reg(REG_ALPHA, 24'd1048576);
        send_item(vec6(-32768, 32767, 0, -1, 300, -300));
        wait_drained();
        // upper data bits fall outside the register and must be dropped
        write_reg(REG_ALPHA, 24'hffffff);
        send_item(vec6(32767, -32768, 32767, -32768, 0, 1));
        send_item(vec6(-32768, 32767, -32768, 32767, 0, -1));
        send_item(vec6(0, 0, 100, -100, 32767, -32768));
        wait_drained();
    endtask

    // Default Butterworth set, then rail coefficients that force saturation.
    task automatic test_biquad();
        write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_BIQUAD));
        send_item(vec6(32767, -32768, 0, 500, -500, 1));
        send_item(vec6(32767, -32768, 0, 500, -500, 1));
        send_item(vec6(-32768, 32767, -1, 0, 0, 0));
        wait_drained();
        write_reg(REG_BIQUAD_B0, 24'h7fffff);
        write_reg(REG_BIQUAD_B1, 24'h800000);
        write_reg(REG_BIQUAD_B2, 24'h7fffff);
        write_reg(REG_BIQUAD_FB1, 24'h800000);
        write_reg(REG_BIQUAD_FB2, 24'h7fffff);
        send_item(vec6(32767, -32768, 1, -1, 0, 20000));
        send_item(vec6(-32768, 32767, -1, 1, 0, -20000));
        send_item(vec6(0, 0, 32767, -32768, 3, -3));
        wait_drained();
    endtask

    // Passthrough, the spare mode code, and a write to the unmapped index.
    task automatic test_passthrough();
        write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_PASS));
        send_item(vec6(32767, -32768, 0, -1, 1, -2));
        send_item(vec6(-32768, 32767, 12, -12, 4096, -4096));
        wait_drained();
        write_reg(REG_FILTER_MODE, 24'hffffff);     // masks to the spare code
        send_item(vec6(-1, 1, 32767, -32768, 0, 77));
        send_item(vec6(2, -2, -32768, 32767, 9, -9));
        wait_drained();
        write_reg(REG_UNMAPPED, 24'h5a5a5a);
        send_item(vec6(32767, 32767, -32768, -32768, 0, 0));
        wait_drained();
    endtask

    // Random register set per phase, random items, random idling; the last
    // phase runs with no idling at all.
    task automatic test_random_phases();
        imu_vec_t prev;
        logic [1:0] mode_pick;
        logic [CFG_DATA_W-1:0] alpha_word;
        prev = '0;
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mode_pick = MODE_LPF;
                4, 5, 6, 7: mode_pick = MODE_BIQUAD;
                8:          mode_pick = MODE_PASS;
                default:    mode_pick = MODE_SPARE;
            endcase
            write_reg(REG_FILTER_MODE,
                      (CFG_DATA_W'($urandom) & ~24'd3) | CFG_DATA_W'(mode_pick));
            case ($urandom_range(0, 4))
                0:       alpha_word = CFG_DATA_W'($urandom_range(0, 1048576));
                1:       alpha_word = ($urandom_range(0, 1) != 0) ? 24'd1048576 : 24'd0;
                2:       alpha_word = CFG_DATA_W'($urandom_range(0, 2097151));
                3:       alpha_word = CFG_DATA_W'($urandom);
                default: alpha_word = CFG_DATA_W'($urandom_range(1000, 300000));
            endcase
            write_reg(REG_ALPHA, alpha_word);
            write_reg(REG_BIQUAD_B0, random_coef(B0_RST));
            write_reg(REG_BIQUAD_B1, random_coef(B1_RST));
            write_reg(REG_BIQUAD_B2, random_coef(B2_RST));
            write_reg(REG_BIQUAD_FB1, random_coef(FB1_RST));
            write_reg(REG_BIQUAD_FB2, random_coef(FB2_RST));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));

            if (p == PHASES - 1) begin
                src_gap_pct     = 0;
                sink_stall_pct  = 0;
                sink_stall_left = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       src_gap_pct = 0;
                    1:       src_gap_pct = 5;
                    2:       src_gap_pct = 20;
                    default: src_gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0:       sink_stall_pct = 0;
                    1:       sink_stall_pct = 5;
                    2:       sink_stall_pct = 20;
                    default: sink_stall_pct = 50;
                endcase
            end

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                prev = random_sample(prev);
                send_item(prev);
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_accel_x      = '0;
        s_accel_y      = '0;
        s_accel_z      = '0;
        s_gyro_x       = '0;
        s_gyro_y       = '0;
        s_gyro_z       = '0;
        fail_count     = 0;
        src_gap_pct    = 15;
        sink_stall_pct = 15;

        // shadow copy starts at the reset values
        cfg_mode    = MODE_LPF;
        cfg_alpha   = longint'(ALPHA_RST);
        cfg_b0      = longint'(B0_RST);
        cfg_b1      = longint'(B1_RST);
        cfg_b2      = longint'(B2_RST);
        cfg_fb1     = longint'(FB1_RST);
        cfg_fb2     = longint'(FB2_RST);
        hist_primed = 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            x_hist1[c] = 0;
            x_hist2[c] = 0;
            y_hist1[c] = 0;
            y_hist2[c] = 0;
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_priming_defaults();
        test_lowpass_alpha_extremes();
        test_biquad();
        test_passthrough();
        test_random_phases();

        if (expected_filtered.size() != 0) begin
            fail_count++;
            $display("%0d result items never arrived", expected_filtered.size());
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/imulp_pkg.sv
sv/imulp_chan.sv
sv/imu_six_axis_lowpass.sv
tb/sv/imu_six_axis_lowpass_tb.sv
